FILE: rtl/cti_pkg.sv
package cti_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = 8;
  localparam int PTS_W       = 9;
  localparam int STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_START  = 5'd2,
    OP_CHK0   = 5'd3,
    OP_CHK1   = 5'd4,
    OP_ISSUE  = 5'd5,
    OP_CMP    = 5'd6,
    OP_SETI0  = 5'd7,
    OP_FETCH  = 5'd8,
    OP_TINIT  = 5'd9,
    OP_MSTART = 5'd10,
    OP_MSTEP  = 5'd11,
    OP_MWB    = 5'd12,
    OP_DSTART = 5'd13,
    OP_DSTEP  = 5'd14,
    OP_DWB    = 5'd15,
    OP_FIN    = 5'd16,
    OP_DEGEN  = 5'd17
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] cnt;
    logic [1:0] k;
    logic [1:0] j;
    logic       sel_den;
  } dp_cmd_t;

  typedef struct packed {
    logic le;
    logic more;
    logic den_zero;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/cti_in_if.sv
interface cti_in_if #(parameter int VW = cti_pkg::VALUE_WIDTH);
  import cti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [IDX_W-1:0]     point_index;
  logic signed [VW-1:0] x_value;
  logic signed [VW-1:0] y_value;
  modport source (output valid, func, point_index, x_value, y_value, input ready);
  modport sink   (input valid, func, point_index, x_value, y_value, output ready);
endinterface

FILE: rtl/cti_out_if.sv
interface cti_out_if #(parameter int VW = cti_pkg::VALUE_WIDTH);
  import cti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] interp_value;
  logic [IDX_W-1:0]     base_index;
  logic [STATUS_W-1:0]  status;
  modport source (output valid, interp_value, base_index, status, input ready);
  modport sink   (input valid, interp_value, base_index, status, output ready);
endinterface

FILE: rtl/cti_cfg_if.sv
interface cti_cfg_if;
  import cti_pkg::*;
  logic             valid;
  logic             ready;
  logic [PTS_W-1:0] points_in_use;
  modport source (output valid, points_in_use, input ready);
  modport sink   (input valid, points_in_use, output ready);
endinterface

FILE: rtl/cubic_table_interpolator_top.sv
// four-point lagrange cubic interpolator over a table of signed fixed-point points.
// a load word (func 0) writes one point. a query word (func 1) takes one item at a
// time: binary search over the x memory, four reads of the neighbouring points, then
// for each of the four terms six products on a shared radix-16 multiplier and one
// restoring division. most of a query's time is spent in the bit-serial divider.
// the result sits in an output register, so the next word is accepted while it
// waits. table memories are not cleared: query only over loaded points.
module cubic_table_interpolator_top #(
  parameter int TABLE_DEPTH = cti_pkg::TABLE_DEPTH,
  parameter int VALUE_WIDTH = cti_pkg::VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  cti_in_if.sink    in_ch,
  cti_out_if.source out_ch,
  cti_cfg_if.sink   cfg_ch
);
  import cti_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  cti_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_func(in_ch.func), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  cti_dp #(.VALUE_WIDTH(VALUE_WIDTH), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_point_index(in_ch.point_index), .in_x_value(in_ch.x_value),
    .in_y_value(in_ch.y_value),
    .cfg_valid(cfg_ch.valid), .cfg_points_in_use(cfg_ch.points_in_use),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_interp_value(out_ch.interp_value), .out_base_index(out_ch.base_index),
    .out_status(out_ch.status)
  );
endmodule

FILE: rtl/cti_ram.sv
module cti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/cti_ctrl.sv
module cti_ctrl #(
  parameter int VALUE_WIDTH = cti_pkg::VALUE_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_func,
  output logic             in_ready,
  input  cti_pkg::dp_sts_t sts,
  output cti_pkg::dp_cmd_t cmd
);
  import cti_pkg::*;

  localparam int WW     = 4 * VALUE_WIDTH + 16;
  localparam int DW     = VALUE_WIDTH + 1;
  localparam int MSTEPS = (DW + 3) / 4;
  localparam int CW     = $clog2(WW);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CHK0  = 16'h0002,
    S_CHK1  = 16'h0004,
    S_LOOP  = 16'h0008,
    S_CMP   = 16'h0010,
    S_FETCH = 16'h0020,
    S_TINIT = 16'h0040,
    S_MST   = 16'h0080,
    S_MSTEP = 16'h0100,
    S_MWB   = 16'h0200,
    S_DZ    = 16'h0400,
    S_DSTEP = 16'h0800,
    S_DWB   = 16'h1000,
    S_FIN   = 16'h2000,
    S_DEGEN = 16'h4000,
    S_SPARE = 16'h8000
  } state_t;

  state_t       state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]   k_r, k_nxt, j_r, j_nxt;
  logic         sel_r, sel_nxt;
  logic [2:0]   j_inc, j_skip;

  always_comb begin
    j_inc  = {1'b0, j_r} + 3'd1;
    j_skip = (j_inc[1:0] == k_r && !j_inc[2]) ? j_inc + 3'd1 : j_inc;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    sel_nxt     = sel_r;
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.cnt     = cnt_r[2:0];
    cmd.k       = k_r;
    cmd.j       = j_r;
    cmd.sel_den = sel_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_QUERY) begin
            cmd.op    = OP_START;
            state_nxt = S_CHK0;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_CHK0: begin
        cmd.op  = OP_CHK0;
        cnt_nxt = '0;
        state_nxt = sts.le ? S_CHK1 : S_FETCH;
      end
      S_CHK1: begin
        cmd.op  = OP_CHK1;
        cnt_nxt = '0;
        state_nxt = sts.le ? S_FETCH : S_LOOP;
      end
      S_LOOP: begin
        cnt_nxt = '0;
        if (sts.more) begin
          cmd.op    = OP_ISSUE;
          state_nxt = S_CMP;
        end else begin
          cmd.op    = OP_SETI0;
          state_nxt = S_FETCH;
        end
      end
      S_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = S_LOOP;
      end
      S_FETCH: begin
        cmd.op = OP_FETCH;
        if (cnt_r[2:0] == 3'd4) begin
          k_nxt     = 2'd0;
          state_nxt = S_TINIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_TINIT: begin
        cmd.op    = OP_TINIT;
        j_nxt     = (k_r == 2'd0) ? 2'd1 : 2'd0;
        sel_nxt   = 1'b0;
        state_nxt = S_MST;
      end
      S_MST: begin
        cmd.op    = OP_MSTART;
        cnt_nxt   = '0;
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.op  = OP_MSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MSTEPS - 1)) begin
          state_nxt = S_MWB;
        end
      end
      S_MWB: begin
        cmd.op = OP_MWB;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_MST;
        end else begin
          sel_nxt = 1'b0;
          if (j_skip[2]) begin
            state_nxt = S_DZ;
          end else begin
            j_nxt     = j_skip[1:0];
            state_nxt = S_MST;
          end
        end
      end
      S_DZ: begin
        cnt_nxt = '0;
        if (sts.den_zero) begin
          state_nxt = S_DEGEN;
        end else begin
          cmd.op    = OP_DSTART;
          state_nxt = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.op  = OP_DSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(WW - 1)) begin
          state_nxt = S_DWB;
        end
      end
      S_DWB: begin
        cmd.op = OP_DWB;
        if (k_r == 2'd3) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_TINIT;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_DEGEN: begin
        if (sts.out_free) begin
          cmd.op    = OP_DEGEN;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      j_r     <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      sel_r   <= sel_nxt;
    end
  end
endmodule

FILE: rtl/cti_dp.sv
module cti_dp #(
  parameter int VALUE_WIDTH = cti_pkg::VALUE_WIDTH,
  parameter int TABLE_DEPTH = cti_pkg::TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cti_pkg::dp_cmd_t              cmd,
  output cti_pkg::dp_sts_t              sts,
  input  logic [cti_pkg::IDX_W-1:0]     in_point_index,
  input  logic signed [VALUE_WIDTH-1:0] in_x_value,
  input  logic signed [VALUE_WIDTH-1:0] in_y_value,
  input  logic                          cfg_valid,
  input  logic [cti_pkg::PTS_W-1:0]     cfg_points_in_use,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_interp_value,
  output logic [cti_pkg::IDX_W-1:0]     out_base_index,
  output logic [cti_pkg::STATUS_W-1:0]  out_status
);
  import cti_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int WW     = 4 * VW + 16;
  localparam int DW     = VW + 1;
  localparam int MSTEPS = (DW + 3) / 4;
  localparam int BW     = 4 * MSTEPS;

  logic [PTS_W-1:0]     pts_r;
  logic signed [VW-1:0] xq_r;
  logic [AW:0]          n_r;
  logic [AW-1:0]        lo_r, hi_r, i0_r;
  logic signed [VW-1:0] xs_r [4];
  logic signed [VW-1:0] ys_r [4];
  logic [WW-1:0]        num_r, den_r, sum_r;
  logic [WW-1:0]        m_acc_r, m_a_r;
  logic [BW-1:0]        m_b_r;
  logic                 m_neg_r;
  logic [WW-1:0]        d_n_r, d_d_r, d_rem_r, d_q_r;
  logic                 d_neg_r;
  logic                 out_valid_r;
  logic signed [VW-1:0] out_val_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [STATUS_W-1:0]  out_st_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, raddr;
  logic [VW-1:0]        rd_x, rd_y;
  logic [AW:0]          mid_sum;
  logic [AW-1:0]        mid, nm1, nm3;
  logic [31:0]          p32, n32;
  logic [2:0]           cm1;
  logic signed [VW-1:0] a_op;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  logic [WW-1:0]        m_res, q_res, rem_sh;
  logic signed [WW-1:0] rnd, max_w, min_w;

  assign ram_we    = (cmd.op == OP_LOAD) && (32'(in_point_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(in_point_index);

  cti_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_xram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_x_value),
    .raddr(raddr), .rdata(rd_x)
  );

  cti_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_yram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_y_value),
    .raddr(raddr), .rdata(rd_y)
  );

  always_comb begin
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
    mid     = mid_sum[AW:1];
    nm1     = AW'(n_r - 1'b1);
    nm3     = AW'(n_r - 2'd3);
    p32     = 32'(pts_r);
    if (p32 < 32'd4) begin
      n32 = 32'd4;
    end else if (p32 > 32'(TABLE_DEPTH)) begin
      n32 = 32'(TABLE_DEPTH);
    end else begin
      n32 = p32;
    end
    case (cmd.op)
      OP_START: raddr = '0;
      OP_CHK0:  raddr = nm1;
      OP_FETCH: raddr = AW'({1'b0, i0_r} - 1'b1 + (AW+1)'(cmd.cnt[1:0]));
      default:  raddr = mid;
    endcase
    cm1  = cmd.cnt - 3'd1;
    a_op = cmd.sel_den ? xs_r[cmd.k] : xq_r;
    diff = DW'(a_op) - DW'(xs_r[cmd.j]);
    mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
    m_res  = m_neg_r ? WW'(-m_acc_r) : m_acc_r;
    q_res  = d_neg_r ? WW'(-d_q_r) : d_q_r;
    rem_sh = {d_rem_r[WW-2:0], d_n_r[WW-1]};
    rnd    = $signed(sum_r + WW'(128)) >>> 8;
    max_w  = WW'($signed({1'b0, {(VW-1){1'b1}}}));
    min_w  = WW'($signed({1'b1, {(VW-1){1'b0}}}));
  end

  assign sts.le       = $signed(rd_x) <= xq_r;
  assign sts.more     = ({1'b0, lo_r} + 1'b1) < {1'b0, hi_r};
  assign sts.den_zero = (den_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        xq_r  <= in_x_value;
        n_r   <= (AW+1)'(n32);
        lo_r  <= '0;
        hi_r  <= AW'(n32 - 32'd1);
        sum_r <= '0;
      end
      OP_CHK0: begin
        if (!sts.le) i0_r <= AW'(1);
      end
      OP_CHK1: begin
        if (sts.le) i0_r <= nm3;
      end
      OP_CMP: begin
        if (sts.le) lo_r <= mid;
        else hi_r <= mid;
      end
      OP_SETI0: begin
        if (lo_r < AW'(1)) i0_r <= AW'(1);
        else if (lo_r > nm3) i0_r <= nm3;
        else i0_r <= lo_r;
      end
      OP_FETCH: begin
        if (cmd.cnt != 3'd0) begin
          xs_r[cm1[1:0]] <= $signed(rd_x);
          ys_r[cm1[1:0]] <= $signed(rd_y);
        end
      end
      OP_TINIT: begin
        num_r <= WW'(ys_r[cmd.k]) << 8;
        den_r <= WW'(1);
      end
      OP_MSTART: begin
        m_neg_r <= diff[DW-1];
        m_b_r   <= BW'(mag);
        m_a_r   <= cmd.sel_den ? den_r : num_r;
        m_acc_r <= '0;
      end
      OP_MSTEP: begin
        // one radix-16 digit per cycle, modular arithmetic keeps the sign
        m_acc_r <= m_acc_r + m_a_r * WW'(m_b_r[3:0]);
        m_a_r   <= m_a_r << 4;
        m_b_r   <= m_b_r >> 4;
      end
      OP_MWB: begin
        if (cmd.sel_den) den_r <= m_res;
        else num_r <= m_res;
      end
      OP_DSTART: begin
        d_neg_r <= num_r[WW-1] ^ den_r[WW-1];
        d_n_r   <= num_r[WW-1] ? WW'(-num_r) : num_r;
        d_d_r   <= den_r[WW-1] ? WW'(-den_r) : den_r;
        d_rem_r <= '0;
        d_q_r   <= '0;
      end
      OP_DSTEP: begin
        d_n_r <= d_n_r << 1;
        if (rem_sh >= d_d_r) begin
          d_rem_r <= rem_sh - d_d_r;
          d_q_r   <= {d_q_r[WW-2:0], 1'b1};
        end else begin
          d_rem_r <= rem_sh;
          d_q_r   <= {d_q_r[WW-2:0], 1'b0};
        end
      end
      OP_DWB: begin
        sum_r <= sum_r + q_res;
      end
      OP_FIN: begin
        out_idx_r <= IDX_W'(i0_r);
        if (rnd > max_w) begin
          out_val_r <= VW'(max_w);
          out_st_r  <= ST_SAT;
        end else if (rnd < min_w) begin
          out_val_r <= VW'(min_w);
          out_st_r  <= ST_SAT;
        end else begin
          out_val_r <= VW'(rnd);
          out_st_r  <= ST_OK;
        end
      end
      OP_DEGEN: begin
        out_idx_r <= IDX_W'(i0_r);
        out_val_r <= '0;
        out_st_r  <= ST_DEGEN;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r       <= PTS_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) pts_r <= cfg_points_in_use;
      if (cmd.op == OP_FIN || cmd.op == OP_DEGEN) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_val_r;
  assign out_base_index   = out_idx_r;
  assign out_status       = out_st_r;
endmodule
